// ===== hw/rtl/sps_pkg.sv =====
// Shared types and constants for the static priority scheduler.
// No dependencies; imported by sps_job_mem, static_priority_scheduler, the checker and the testbench.
`timescale 1ns / 1ps

package sps_pkg;

    // Time values wrap at this width
    localparam int TIME_W = 21;
    localparam int ARR_W  = 16;
    localparam int SVC_W  = 16;
    localparam int PRIO_W = 8;
    localparam int JOBN_W = 4;

    // Input transaction: one job
    typedef struct packed {
        logic [ARR_W-1:0]  arrival_time;
        logic [SVC_W-1:0]  service_time;
        logic [PRIO_W-1:0] job_priority;
        logic              is_last;
    } job_t;

    // Output transaction: one completed job
    typedef struct packed {
        logic [JOBN_W-1:0] job_number;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic              last_result;
    } result_t;

    // One stored job entry
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [SVC_W-1:0]  service;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_PICK
    } state_t;

endpackage

// ===== hw/rtl/sps_job_mem.sv =====
// Job store: one write port, one read port with registered read data.
// Depends on sps_pkg for the entry type.
`timescale 1ns / 1ps

module sps_job_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  sps_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output sps_pkg::entry_t       rd_data
);
    import sps_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/static_priority_scheduler.sv =====
// Non-preemptive static priority scheduler. Jobs load one per cycle into an
// on-chip store; the job marked last (or the MAX_JOBS-th job) starts the run.
// Each selection is a pass over the store through its single read port,
// plus one more pass whenever no job has arrived yet and time jumps to the
// next arrival. A batch gives one result per job in run order, and the
// result side may stall them. Jobs are not accepted while a batch is being
// scheduled.
// Depends on sps_pkg and sps_job_mem.
`timescale 1ns / 1ps

module static_priority_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_stall,
    input  sps_pkg::job_t     job,
    output logic              res_valid,
    input  logic              res_stall,
    output sps_pkg::result_t  res
);
    import sps_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    finished_reg, finished_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [MAX_JOBS-1:0] done_reg, done_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                best_found_reg, best_found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]   best_prio_reg, best_prio_next;
    logic [ARR_W-1:0]    best_arr_reg, best_arr_next;
    logic [SVC_W-1:0]    best_svc_reg, best_svc_next;
    logic [ARR_W-1:0]    min_arr_reg, min_arr_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    entry_t              mem_rdata;

    logic                issue;
    logic                batch_end;
    logic [TIME_W-1:0]   finish;

    sps_job_mem #(
        .DEPTH (MAX_JOBS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    assign mem_waddr = loaded_reg[IDX_W-1:0];
    assign mem_wdata = '{arrival: job.arrival_time, service: job.service_time,
                         prio: job.job_priority};
    assign issue     = (state_reg == S_SCAN) && (scan_idx_reg < loaded_reg);
    assign mem_re    = issue;
    assign finish    = time_reg + TIME_W'(best_svc_reg);
    assign batch_end = job.is_last || (loaded_reg == CNT_W'(MAX_JOBS - 1));

    assign job_stall = (state_reg != S_LOAD);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Next state, scan evaluation and result staging
    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        finished_next   = finished_reg;
        time_next       = time_reg;
        done_next       = done_reg;
        scan_idx_next   = scan_idx_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = scan_idx_reg[IDX_W-1:0];
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_arr_next   = best_arr_reg;
        best_svc_next   = best_svc_reg;
        min_arr_next    = min_arr_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && res_stall;
        mem_we          = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                // Store the job and start the run on the batch's final job
                if (job_valid)
                begin
                    mem_we      = 1'b1;
                    loaded_next = loaded_reg + 1'b1;
                    if (batch_end)
                    begin
                        state_next      = S_SCAN;
                        scan_idx_next   = '0;
                        best_found_next = 1'b0;
                        min_arr_next    = '1;
                    end
                end
            end

            S_SCAN:
            begin
                // Advance the read address over the loaded jobs
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                rd_valid_next = issue;

                // Compare the entry read last cycle against the running best
                if (rd_valid_reg && !done_reg[rd_idx_reg])
                begin
                    if (mem_rdata.arrival < min_arr_reg)
                    begin
                        min_arr_next = mem_rdata.arrival;
                    end
                    if ((TIME_W'(mem_rdata.arrival) <= time_reg) &&
                        (!best_found_reg || (mem_rdata.prio > best_prio_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_prio_next  = mem_rdata.prio;
                        best_arr_next   = mem_rdata.arrival;
                        best_svc_next   = mem_rdata.service;
                    end
                end

                if (!issue && !rd_valid_reg)
                begin
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                if (best_found_reg)
                begin
                    // Run the chosen job once the result register is free
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.job_number     = JOBN_W'(best_idx_reg);
                        res_next.finish_time    = finish;
                        res_next.turnaround     = finish - TIME_W'(best_arr_reg);
                        res_next.last_result    = (finished_reg + 1'b1) == loaded_reg;
                        time_next               = finish;
                        done_next[best_idx_reg] = 1'b1;
                        finished_next           = finished_reg + 1'b1;
                        scan_idx_next           = '0;
                        best_found_next         = 1'b0;
                        min_arr_next            = '1;
                        if ((finished_reg + 1'b1) == loaded_reg)
                        begin
                            // Clear batch state for the next batch
                            state_next    = S_LOAD;
                            loaded_next   = '0;
                            finished_next = '0;
                            time_next     = '0;
                            done_next     = '0;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
                else
                begin
                    // Nothing ready: jump time to the earliest pending arrival
                    if (TIME_W'(min_arr_reg) > time_reg)
                    begin
                        time_next = TIME_W'(min_arr_reg);
                    end
                    state_next    = S_SCAN;
                    scan_idx_next = '0;
                    min_arr_next  = '1;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= '0;
            finished_reg   <= '0;
            time_reg       <= '0;
            done_reg       <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            loaded_reg     <= loaded_next;
            finished_reg   <= finished_next;
            time_reg       <= time_next;
            done_reg       <= done_next;
            scan_idx_reg   <= scan_idx_next;
            rd_valid_reg   <= rd_valid_next;
            best_found_reg <= best_found_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_arr_reg  <= best_arr_next;
        best_svc_reg  <= best_svc_next;
        min_arr_reg   <= min_arr_next;
        res_reg       <= res_next;
    end

endmodule

// ===== dv/static_priority_scheduler_chk.sv =====
// Checker for the static priority scheduler: watches both channels, predicts
// the run order of each batch and compares every result. Depends on sps_pkg.
`timescale 1ns / 1ps

module static_priority_scheduler_chk #(
    parameter int MAX_JOBS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  logic              job_stall,
    input  sps_pkg::job_t     job,
    input  logic              res_valid,
    input  logic              res_stall,
    input  sps_pkg::result_t  res,
    output int                fail_count,
    output int                pending
);

    import sps_pkg::*;

    // Jobs of the batch being loaded, in load order
    entry_t  batch_jobs_q[$];
    // Predicted results, oldest first
    result_t run_order_q[$];

    task automatic note_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Run the loaded batch to completion and queue one result per job
    function automatic void schedule_batch();
        logic [TIME_W-1:0] now;
        logic [ARR_W-1:0]  next_arr;
        bit                ran [MAX_JOBS];
        int                finished;
        int                pick;
        result_t           r;
        now      = '0;
        finished = 0;
        foreach (ran[i])
            ran[i] = 1'b0;
        while (finished < batch_jobs_q.size())
        begin
            // Highest priority among arrived jobs; ties keep the lower number
            pick = -1;
            for (int i = 0; i < batch_jobs_q.size(); i++)
                if (!ran[i] && batch_jobs_q[i].arrival <= now &&
                    (pick < 0 || batch_jobs_q[i].prio > batch_jobs_q[pick].prio))
                    pick = i;
            if (pick < 0)
            begin
                // Nothing ready: jump to the earliest pending arrival
                next_arr = '1;
                for (int i = 0; i < batch_jobs_q.size(); i++)
                    if (!ran[i] && batch_jobs_q[i].arrival < next_arr)
                        next_arr = batch_jobs_q[i].arrival;
                if (next_arr > now)
                    now = next_arr;
            end
            else
            begin
                now = now + batch_jobs_q[pick].service;
                ran[pick] = 1'b1;
                finished++;
                r.job_number  = JOBN_W'(pick);
                r.finish_time = now;
                r.turnaround  = now - batch_jobs_q[pick].arrival;
                r.last_result = (finished == batch_jobs_q.size());
                run_order_q.insert(run_order_q.size(), r);
            end
        end
        batch_jobs_q.delete();
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            note_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Compare one accepted result against the oldest prediction
    task automatic check_result(input result_t got);
        result_t want;
        if (run_order_q.size() == 0)
        begin
            note_error($sformatf("result for job %0d with nothing expected",
                                 got.job_number));
            return;
        end
        want = run_order_q.pop_front();
        check_field("job_number", TIME_W'(got.job_number), TIME_W'(want.job_number));
        check_field("finish_time", got.finish_time, want.finish_time);
        check_field("turnaround", got.turnaround, want.turnaround);
        check_field("last_result", TIME_W'(got.last_result), TIME_W'(want.last_result));
    endtask

    // Sample both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_result(res);
            // Store the job; a last mark or a full store closes the batch
            if (job_valid && !job_stall)
            begin
                batch_jobs_q.insert(batch_jobs_q.size(),
                                    entry_t'{arrival: job.arrival_time,
                                             service: job.service_time,
                                             prio:    job.job_priority});
                if (job.is_last || batch_jobs_q.size() == MAX_JOBS)
                    schedule_batch();
            end
            pending = run_order_q.size();
        end
    end

endmodule

// ===== dv/static_priority_scheduler_tb.sv =====
// Testbench top for the static priority scheduler: clock, reset, job batches
// and result back-pressure. Depends on sps_pkg, the block and its checker.
`timescale 1ns / 1ps

module static_priority_scheduler_tb;

    import sps_pkg::*;

    localparam int NUM_SLOTS       = 16;
    localparam int TARGET_JOBS     = 280;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 600;
    localparam int HOLD_OFF_CYCLES = 800;

    logic    clk;
    logic    rst_n;
    logic    job_valid;
    logic    job_stall;
    job_t    job;
    logic    res_valid;
    logic    res_stall;
    result_t res;

    int      fail_count;
    int      pending_results;
    int      cycle_count;
    int      jobs_sent;
    bit      hold_off_req;

    static_priority_scheduler #(.MAX_JOBS(NUM_SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job       (job),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    static_priority_scheduler_chk #(.MAX_JOBS(NUM_SLOTS)) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_stall  (job_stall),
        .job        (job),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Mostly short gaps, a few long ones, none inside a busy stretch
    function automatic int idle_len(input bit busy);
        int r;
        if (busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic job_t make_job(input int arr, input int svc, input int prio,
                                      input bit last);
        job_t j;
        j.arrival_time = ARR_W'(arr);
        j.service_time = SVC_W'(svc);
        j.job_priority = PRIO_W'(prio);
        j.is_last      = last;
        return j;
    endfunction

    // Offer one transaction after an idle gap and hold it until accepted
    task automatic send_job(input job_t item, input int gap);
        if (gap > 0)
        begin
            job_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        job_valid <= 1'b1;
        job       <= item;
        do
            @(posedge clk);
        while (job_stall !== 1'b0);
        jobs_sent++;
    endtask

    // Send one batch of n jobs with randomly shaped timing and priorities
    task automatic send_batch(input int n, input bit busy);
        int arr_mode;
        int svc_mode;
        int prio_mode;
        int prio_base;
        int cursor;
        int arr;
        int svc;
        int prio;
        bit last;
        arr_mode  = $urandom_range(0, 3);
        svc_mode  = $urandom_range(0, 2);
        prio_mode = $urandom_range(0, 2);
        prio_base = $urandom_range(0, 255);
        cursor    = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++)
        begin
            case (arr_mode)
                0: arr = $urandom_range(0, 15);
                1: arr = $urandom() & 16'hFFFF;
                2:
                begin
                    arr    = cursor;
                    cursor = cursor + $urandom_range(0, 4000);
                    if (cursor > 65535)
                        cursor = 65535;
                end
                default: arr = 0;
            endcase
            case (svc_mode)
                0: svc = $urandom_range(0, 3);
                1: svc = $urandom_range(0, 200);
                default: svc = $urandom() & 16'hFFFF;
            endcase
            case (prio_mode)
                0: prio = $urandom_range(0, 2);
                1: prio = $urandom_range(0, 255);
                default: prio = prio_base;
            endcase
            if (i != n - 1)
                last = 1'b0;
            else if (n == NUM_SLOTS)
                last = $urandom_range(0, 1);
            else
                last = 1'b1;
            send_job(make_job(arr, svc, prio, last), idle_len(busy));
        end
    endtask

    // Stop a hung run
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls in stretches, plus one long hold-off on request
    initial
    begin : result_side
        int stretch_left;
        int stall_len;
        bit calm;
        bit hold_off_done;
        res_stall     <= 1'b0;
        stretch_left  = 0;
        calm          = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch_left <= 0)
            begin
                stretch_left = $urandom_range(20, 120);
                calm         = ($urandom_range(0, 3) == 0);
            end
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                stall_len     = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall_len = idle_len(calm);
            end
            stretch_left -= stall_len + 1;
            res_stall    <= (stall_len != 0);
            repeat (stall_len) @(posedge clk);
        end
    end

    // Job side: reset, directed batches, random batches, then drain
    initial
    begin : job_side
        bit pressure_done;
        int r;
        int n;
        rst_n         <= 1'b0;
        job_valid     <= 1'b0;
        job           <= '0;
        jobs_sent     = 0;
        pressure_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single job, all fields zero, zero service time
        send_job(make_job(0, 0, 0, 1'b1), idle_len(1'b0));
        // Field maxima on a job that arrives last, forcing an idle jump
        send_job(make_job(65535, 65535, 255, 1'b0), idle_len(1'b0));
        send_job(make_job(0, 0, 0, 1'b1), idle_len(1'b0));
        // Equal priorities go to the lower job number
        send_job(make_job(0, 5, 7, 1'b0), idle_len(1'b0));
        send_job(make_job(0, 3, 7, 1'b1), idle_len(1'b0));
        // Priority against arrival, then a late job after an idle gap
        send_job(make_job(0, 10, 1, 1'b0), idle_len(1'b0));
        send_job(make_job(2, 4, 9, 1'b0), idle_len(1'b0));
        send_job(make_job(1, 4, 200, 1'b0), idle_len(1'b0));
        send_job(make_job(100, 1, 50, 1'b1), idle_len(1'b0));
        // Full store closes the batch without a last mark; latest finish time
        for (int i = 0; i < NUM_SLOTS; i++)
            send_job(make_job(65535, 65535, i % 3, 1'b0), idle_len(1'b0));

        // Random batches, mostly small; one full batch under a long hold-off
        while (jobs_sent < TARGET_JOBS)
        begin
            if (!pressure_done && jobs_sent >= 120)
            begin
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
                send_batch(NUM_SLOTS, 1'b1);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    n = $urandom_range(1, 5);
                else if (r < 85)
                    n = $urandom_range(6, 12);
                else if (r < 93)
                    n = $urandom_range(13, 15);
                else
                    n = NUM_SLOTS;
                send_batch(n, $urandom_range(0, 4) == 0);
            end
        end
        job_valid <= 1'b0;

        // Wait for every predicted result, then watch for strays
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
